FILE: hw/rtl/qbvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbvs_pkg
// Shared constants, codes and controller/datapath interface types for the
// quad batch vertex setup block.
// ----------------------------------------------------------------------------
package qbvs_pkg;

   localparam int TEXTURE_SLOTS  = 32;
   localparam int SLOT_W         = $clog2(TEXTURE_SLOTS);
   localparam int SLOT_CNT_W     = $clog2(TEXTURE_SLOTS + 1);
   localparam int MAX_QUAD_COUNT = 16384;
   localparam int QUAD_CNT_W     = $clog2(MAX_QUAD_COUNT + 1);

   localparam int CORDIC_STEPS   = 16;
   localparam int STEP_W         = $clog2(CORDIC_STEPS);

   localparam logic MODE_BEGIN = 1'b0;
   localparam logic MODE_QUAD  = 1'b1;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_SLOTS_FULL = 2'd1;
   localparam logic [1:0] ST_QUADS_FULL = 2'd2;

   localparam logic signed [24:0] CORDIC_ATAN [CORDIC_STEPS] = '{
      25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
      25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
      25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
      25'sd917,     25'sd458,     25'sd229,    25'sd115
   };

   typedef struct packed {
      logic              latch;
      logic              clear;
      logic              rd;
      logic              hit_commit;
      logic              miss_commit;
      logic              cordic_init;
      logic              cordic_step;
      logic              round;
      logic              mul;
      logic              vert;
      logic              err;
      logic [SLOT_W-1:0] idx;
      logic [STEP_W-1:0] step;
      logic [1:0]        mul_sel;
      logic [1:0]        corner;
      logic [1:0]        err_status;
   } dp_cmd_type;

   typedef struct packed {
      logic                  mode;
      logic                  quad_full;
      logic                  slot_hit;
      logic                  slots_full;
      logic [SLOT_CNT_W-1:0] slots_used;
      logic                  out_last;
   } dp_stat_type;

endpackage

FILE: hw/rtl/qbvs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbvs_datapath
// Input latch, texture slot memory, counters, iterative CORDIC, shared
// multiplier and vertex output register.
// ----------------------------------------------------------------------------
module qbvs_datapath import qbvs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  dp_cmd_type   cmd,
   output dp_stat_type  stat,
   input  logic         in_mode,
   input  logic [255:0] in_data,
   output logic [151:0] out_data,
   output logic [1:0]   out_status,
   output logic         out_last
);

   logic                         mode_ff;
   logic signed [31:0]           px_ff, py_ff, szx_ff, szy_ff;
   logic [31:0]                  pz_ff, color_ff, handle_ff;
   logic signed [15:0]           angle_ff;
   logic [15:0]                  tiling_ff;

   logic [31:0]                  slot_mem [TEXTURE_SLOTS];
   logic [31:0]                  rdata_ff;
   logic [SLOT_CNT_W-1:0]        slots_used_ff;
   logic [QUAD_CNT_W-1:0]        quad_count_ff;
   logic [SLOT_W-1:0]            slot_ff;

   logic signed [33:0]           x_ff, y_ff;
   logic signed [24:0]           z_ff;
   logic [1:0]                   quad_ff;
   logic signed [17:0]           c_ff, s_ff;
   logic signed [49:0]           prod_ff [4];

   logic signed [31:0]           vx_ff, vy_ff;
   logic [31:0]                  vz_ff, vcolor_ff;
   logic                         tu_ff, tv_ff, last_ff;
   logic [SLOT_W-1:0]            vslot_ff;
   logic [15:0]                  vtiling_ff;
   logic [1:0]                   status_ff;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      if (v > 36'sd2147483647) begin
         sat32 = 32'sh7fffffff;
      end else if (v < -36'sd2147483648) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   // angle reduction
   logic signed [17:0] a_ext, r_red;
   logic [1:0]         q_in;
   logic signed [17:0] rem;
   always_comb begin
      a_ext = 18'(angle_ff);
      if (a_ext < -18'sd23040) begin
         r_red = a_ext + 18'sd46080;
      end else if (a_ext < 18'sd0) begin
         r_red = a_ext + 18'sd23040;
      end else if (a_ext >= 18'sd23040) begin
         r_red = a_ext - 18'sd23040;
      end else begin
         r_red = a_ext;
      end
      if (r_red >= 18'sd17280) begin
         q_in = 2'd3; rem = r_red - 18'sd17280;
      end else if (r_red >= 18'sd11520) begin
         q_in = 2'd2; rem = r_red - 18'sd11520;
      end else if (r_red >= 18'sd5760) begin
         q_in = 2'd1; rem = r_red - 18'sd5760;
      end else begin
         q_in = 2'd0; rem = r_red;
      end
   end

   logic signed [33:0] dx, dy;
   assign dx = y_ff >>> cmd.step;
   assign dy = x_ff >>> cmd.step;

   logic signed [33:0] xr, yr;
   logic signed [17:0] c0, s0;
   assign xr = x_ff + 34'sd8192;
   assign yr = y_ff + 34'sd8192;
   assign c0 = 18'(xr >>> 14);
   assign s0 = 18'(yr >>> 14);

   logic signed [31:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [49:0] mul_p;
   always_comb begin
      mul_a = (cmd.mul_sel == 2'd0 || cmd.mul_sel == 2'd2) ? szx_ff : szy_ff;
      mul_b = (cmd.mul_sel == 2'd0 || cmd.mul_sel == 2'd3) ? c_ff : s_ff;
      mul_p = 50'(mul_a * mul_b);
   end

   logic               negx, negy;
   logic signed [51:0] t1, t2, t3, t4, sum_x, sum_y;
   logic signed [35:0] vx_in, vy_in;
   always_comb begin
      negx  = (cmd.corner == 2'd0) || (cmd.corner == 2'd3);
      negy  = (cmd.corner == 2'd0) || (cmd.corner == 2'd1);
      t1    = negx ? -52'(prod_ff[0]) : 52'(prod_ff[0]);
      t2    = negy ? 52'(prod_ff[1]) : -52'(prod_ff[1]);
      t3    = negx ? -52'(prod_ff[2]) : 52'(prod_ff[2]);
      t4    = negy ? -52'(prod_ff[3]) : 52'(prod_ff[3]);
      sum_x = t1 + t2 + 52'sd65536;
      sum_y = t3 + t4 + 52'sd65536;
      vx_in = 36'(px_ff) + 36'(sum_x >>> 17);
      vy_in = 36'(py_ff) + 36'(sum_y >>> 17);
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff   <= in_mode;
         px_ff     <= in_data[31:0];
         py_ff     <= in_data[63:32];
         pz_ff     <= in_data[95:64];
         szx_ff    <= in_data[127:96];
         szy_ff    <= in_data[159:128];
         angle_ff  <= in_data[175:160];
         color_ff  <= in_data[207:176];
         handle_ff <= in_data[239:208];
         tiling_ff <= in_data[255:240];
      end
      if (cmd.rd) begin
         rdata_ff <= slot_mem[cmd.idx];
      end
      if (cmd.miss_commit) begin
         slot_mem[slots_used_ff[SLOT_W-1:0]] <= handle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_used_ff <= '0;
         quad_count_ff <= '0;
      end else if (cmd.clear) begin
         slots_used_ff <= '0;
         quad_count_ff <= '0;
      end else begin
         if (cmd.miss_commit) begin
            slots_used_ff <= slots_used_ff + SLOT_CNT_W'(1);
         end
         if (cmd.hit_commit || cmd.miss_commit) begin
            quad_count_ff <= quad_count_ff + QUAD_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hit_commit) begin
         slot_ff <= cmd.idx;
      end else if (cmd.miss_commit) begin
         slot_ff <= slots_used_ff[SLOT_W-1:0];
      end
      if (cmd.cordic_init) begin
         x_ff    <= 34'sd652032874;
         y_ff    <= '0;
         z_ff    <= 25'(rem) <<< 10;
         quad_ff <= q_in;
      end else if (cmd.cordic_step) begin
         if (z_ff >= 25'sd0) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - CORDIC_ATAN[cmd.step];
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + CORDIC_ATAN[cmd.step];
         end
      end
      if (cmd.round) begin
         case (quad_ff)
            2'd0:    begin c_ff <= c0;  s_ff <= s0;  end
            2'd1:    begin c_ff <= -s0; s_ff <= c0;  end
            2'd2:    begin c_ff <= -c0; s_ff <= -s0; end
            default: begin c_ff <= s0;  s_ff <= -c0; end
         endcase
      end
      if (cmd.mul) begin
         prod_ff[cmd.mul_sel] <= mul_p;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.vert) begin
         vx_ff      <= sat32(vx_in);
         vy_ff      <= sat32(vy_in);
         vz_ff      <= pz_ff;
         vcolor_ff  <= color_ff;
         tu_ff      <= (cmd.corner == 2'd1) || (cmd.corner == 2'd2);
         tv_ff      <= cmd.corner[1];
         vslot_ff   <= slot_ff;
         vtiling_ff <= tiling_ff;
         status_ff  <= ST_OK;
         last_ff    <= (cmd.corner == 2'd3);
      end else if (cmd.err) begin
         vx_ff      <= '0;
         vy_ff      <= '0;
         vz_ff      <= '0;
         vcolor_ff  <= '0;
         tu_ff      <= 1'b0;
         tv_ff      <= 1'b0;
         vslot_ff   <= '0;
         vtiling_ff <= '0;
         status_ff  <= cmd.err_status;
         last_ff    <= 1'b1;
      end
   end

   assign stat.mode       = mode_ff;
   assign stat.quad_full  = (quad_count_ff >= QUAD_CNT_W'(MAX_QUAD_COUNT));
   assign stat.slot_hit   = (rdata_ff == handle_ff);
   assign stat.slots_full = (slots_used_ff == SLOT_CNT_W'(TEXTURE_SLOTS));
   assign stat.slots_used = slots_used_ff;
   assign stat.out_last   = last_ff;

   assign out_data   = {1'b0, vtiling_ff, vslot_ff, tv_ff, tu_ff, vcolor_ff, vz_ff,
                        vy_ff, vx_ff};
   assign out_status = status_ff;
   assign out_last   = last_ff;

   a_slots_bound: assert property (@(posedge clock) disable iff (reset)
      slots_used_ff <= SLOT_CNT_W'(TEXTURE_SLOTS))
      else $error("slot count overran table");
   a_quad_bound: assert property (@(posedge clock) disable iff (reset)
      quad_count_ff <= QUAD_CNT_W'(MAX_QUAD_COUNT))
      else $error("quad count overran buffer");
   a_miss_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.miss_commit |-> !stat.slots_full)
      else $error("slot insert into a full table");

endmodule

FILE: hw/rtl/qbvs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbvs_ctrl
// Sequencer for slot lookup, CORDIC iterations, products and vertex beats.
// ----------------------------------------------------------------------------
module qbvs_ctrl import qbvs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_RD     = 4'd2;
   localparam logic [3:0] S_CMP    = 4'd3;
   localparam logic [3:0] S_MISS   = 4'd4;
   localparam logic [3:0] S_CORDIC = 4'd5;
   localparam logic [3:0] S_ROUND  = 4'd6;
   localparam logic [3:0] S_MUL    = 4'd7;
   localparam logic [3:0] S_VERT   = 4'd8;
   localparam logic [3:0] S_OUT    = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [1:0]        msel_ff, msel_in;
   logic [1:0]        corner_ff, corner_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      idx_in     = idx_ff;
      step_in    = step_ff;
      msel_in    = msel_ff;
      corner_in  = corner_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.mode == MODE_BEGIN) begin
               cmd.clear = 1'b1;
               state_in  = S_IDLE;
            end else if (stat.quad_full) begin
               cmd.err        = 1'b1;
               cmd.err_status = ST_QUADS_FULL;
               state_in       = S_OUT;
            end else if (stat.slots_used == '0) begin
               state_in = S_MISS;
            end else begin
               idx_in   = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            cmd.idx  = idx_ff;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.idx = idx_ff;
            if (stat.slot_hit) begin
               cmd.hit_commit  = 1'b1;
               cmd.cordic_init = 1'b1;
               step_in         = '0;
               state_in        = S_CORDIC;
            end else if ({1'b0, idx_ff} + SLOT_CNT_W'(1) == stat.slots_used) begin
               state_in = S_MISS;
            end else begin
               idx_in   = idx_ff + SLOT_W'(1);
               state_in = S_RD;
            end
         end
         S_MISS: begin
            if (stat.slots_full) begin
               cmd.err        = 1'b1;
               cmd.err_status = ST_SLOTS_FULL;
               state_in       = S_OUT;
            end else begin
               cmd.miss_commit = 1'b1;
               cmd.cordic_init = 1'b1;
               step_in         = '0;
               state_in        = S_CORDIC;
            end
         end
         S_CORDIC: begin
            cmd.cordic_step = 1'b1;
            cmd.step        = step_ff;
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = S_ROUND;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            msel_in   = '0;
            state_in  = S_MUL;
         end
         S_MUL: begin
            cmd.mul     = 1'b1;
            cmd.mul_sel = msel_ff;
            if (msel_ff == 2'd3) begin
               corner_in = '0;
               state_in  = S_VERT;
            end else begin
               msel_in = msel_ff + 2'd1;
            end
         end
         S_VERT: begin
            cmd.vert   = 1'b1;
            cmd.corner = corner_ff;
            state_in   = S_OUT;
         end
         S_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (stat.out_last) begin
                  state_in = S_IDLE;
               end else begin
                  corner_in = corner_ff + 2'd1;
                  state_in  = S_VERT;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff    <= idx_in;
      step_ff   <= step_in;
      msel_ff   <= msel_in;
      corner_ff <= corner_in;
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and output open together");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && stat.out_last |=> state_ff == S_IDLE)
      else $error("did not return to idle after last beat");
   a_begin_silent: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DECODE && stat.mode == MODE_BEGIN |=> !rsp_tvalid)
      else $error("begin item produced a beat");

endmodule

FILE: hw/rtl/quad_batch_vertex_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_batch_vertex_setup
// Sprite quad vertex generation with texture slot batching, Q16.16.
// ----------------------------------------------------------------------------
// req channel: one beat per item; tuser is the mode (begin frame or quad).
// A begin beat clears the slot table and quad count and yields no rsp beat.
// A quad beat yields four vertex beats, tlast on the fourth, or one beat with a
// full status in tuser when the quad buffer is full or a miss finds the slot table full.
// Steps per quad: decode, then a search of the slot entries, one read and
// one compare per entry (0..32 entries, one slot memory read port), an insert
// on a miss, 16 CORDIC iterations, a round, 4 products on the one shared
// multiplier, then a vertex register load and an output beat per vertex.
// The block works on one item at a time; req_tready is high only when idle.
// Reset clears the state machine, slot count and quad count; slot contents
// are only read below the count.
// When the receiver stalls, the current vertex beat holds until taken.
// ----------------------------------------------------------------------------
module quad_batch_vertex_setup import qbvs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, size_x, size_y, angle_deg[16], color_rgba,
   // texture_handle, tiling[16]
   input  logic [255:0] req_tdata,
   // mode
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // vert_x, vert_y, vert_z, vert_color, tex_u, tex_v, slot[5],
   // vert_tiling[16], pad
   output logic [151:0] rsp_tdata,
   // status
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   qbvs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   qbvs_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_mode    (req_tuser),
      .in_data    (req_tdata),
      .out_data   (rsp_tdata),
      .out_status (rsp_tuser),
      .out_last   (rsp_tlast)
   );

endmodule
